// ----- rtl/pf_pkg.sv -----
// ----------------------------------------------------------------------------
// pf_pkg: shared definitions for the prime factorizer
// Default operand width and the status word of the serial divider.
// ----------------------------------------------------------------------------
package pf_pkg;

  localparam int VALUE_BITS_DEFAULT = 31;

  // Status of the shared divider as seen by the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } pf_div_stat_t;

endpackage

// ----- rtl/pf_stream_if.sv -----
// ----------------------------------------------------------------------------
// pf_stream_if: request channels of the prime factorizer
// Operand channel carries one value, result channel one factor and a last mark.
// ----------------------------------------------------------------------------
interface pf_value_if import pf_pkg::*; #(
  parameter int VALUE_BITS = VALUE_BITS_DEFAULT
);
  logic                  valid;
  logic                  ready;
  logic [VALUE_BITS-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface pf_factor_if import pf_pkg::*; #(
  parameter int VALUE_BITS = VALUE_BITS_DEFAULT
);
  logic                  valid;
  logic                  ready;
  logic [VALUE_BITS-1:0] factor;
  logic                  last;

  modport source (output valid, output factor, output last, input ready);
  modport sink   (input valid, input factor, input last, output ready);
endinterface

// ----- rtl/pf_divider.sv -----
// ----------------------------------------------------------------------------
// pf_divider: restoring serial divider
// One quotient bit per cycle; quotient and remainder are valid once done is raised.
// ----------------------------------------------------------------------------
module pf_divider import pf_pkg::*; #(
  parameter int VALUE_BITS = VALUE_BITS_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [VALUE_BITS-1:0] dividend,
  input  logic [VALUE_BITS-1:0] divisor,
  output logic [VALUE_BITS-1:0] quotient,
  output logic [VALUE_BITS-1:0] remainder,
  output pf_div_stat_t          stat
);

  localparam int CNT_W = $clog2(VALUE_BITS);

  logic                  busy;
  logic                  done;
  logic [CNT_W-1:0]      cnt;
  logic [VALUE_BITS-1:0] acc;
  logic [VALUE_BITS-1:0] dsh;
  logic [VALUE_BITS-1:0] dvs;

  logic [VALUE_BITS+1:0] diff;
  logic                  fits;
  logic [VALUE_BITS-1:0] acc_next;
  logic [VALUE_BITS-1:0] dsh_next;

  // trial subtract of the divisor from the shifted partial remainder
  always_comb begin
    diff     = {1'b0, acc, dsh[VALUE_BITS-1]} - {2'b00, dvs};
    fits     = ~diff[VALUE_BITS+1];
    acc_next = fits ? diff[VALUE_BITS-1:0] : {acc[VALUE_BITS-2:0], dsh[VALUE_BITS-1]};
    dsh_next = {dsh[VALUE_BITS-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(VALUE_BITS - 1);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath: load on start, advance while busy
  always_ff @(posedge clk) begin
    if (start) begin
      acc <= '0;
      dsh <= dividend;
      dvs <= divisor;
    end else if (busy) begin
      acc <= acc_next;
      dsh <= dsh_next;
    end
  end

  assign quotient  = dsh;
  assign remainder = acc;
  assign stat.busy = busy;
  assign stat.done = done;

endmodule

// ----- rtl/prime_factorizer_top.sv -----
// ----------------------------------------------------------------------------
// prime_factorizer_top: trial-division prime factorizer
// Takes one positive integer and emits its prime factors in ascending order.
// ----------------------------------------------------------------------------
// Usage:
//   operand : one request carries value (VALUE_BITS bits, unsigned).
//   result  : one request per prime factor, ascending, repeats included;
//             last marks the final factor of the value. Value 1 gives the
//             single factor 1; value 0 gives no result at all.
// Operation:
//   Each trial divisor costs one pass of the shared serial divider; a prime
//   near 2^31 needs some 46341 trials. Trials stop once the divisor exceeds
//   remainder / divisor, and the remainder is emitted.
//   Operand ready is high only while the block is idle; one item at a time.
// Reset:
//   rst (synchronous, active high) returns the sequencer to idle and drops
//   any partly emitted result.
// Stall:
//   A result holds in the output register while the receiver is not ready;
//   the next trial division starts only once that result is taken.
// ----------------------------------------------------------------------------
module prime_factorizer_top import pf_pkg::*; #(
  parameter int VALUE_BITS = VALUE_BITS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  pf_value_if.sink    operand,
  pf_factor_if.source result
);

  // sequencer states
  localparam logic [1:0] S_IDLE = 2'd0;  // waiting for a request
  localparam logic [1:0] S_DIV  = 2'd1;  // divider running on rem / d
  localparam logic [1:0] S_OUT  = 2'd2;  // factor waiting in output register

  logic [1:0]            state;
  logic [1:0]            state_next;
  logic [VALUE_BITS-1:0] rem;
  logic [VALUE_BITS-1:0] rem_next;
  logic [VALUE_BITS-1:0] d;
  logic [VALUE_BITS-1:0] d_next;
  logic [VALUE_BITS-1:0] out_factor;
  logic [VALUE_BITS-1:0] out_factor_next;
  logic                  out_last;
  logic                  out_last_next;

  logic                  div_start;
  logic [VALUE_BITS-1:0] div_dividend;
  logic [VALUE_BITS-1:0] div_divisor;
  logic [VALUE_BITS-1:0] div_quot;
  logic [VALUE_BITS-1:0] div_rem;
  pf_div_stat_t          div_stat;

  // Shared divider: gives rem / d and rem % d in one pass. The quotient
  // also serves the stop test, as d * d <= rem exactly when d <= rem / d.
  pf_divider #(
    .VALUE_BITS (VALUE_BITS)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .quotient  (div_quot),
    .remainder (div_rem),
    .stat      (div_stat)
  );

  always_comb begin
    state_next      = state;
    rem_next        = rem;
    d_next          = d;
    out_factor_next = out_factor;
    out_last_next   = out_last;
    div_start       = 1'b0;
    div_dividend    = rem;
    div_divisor     = d;

    case (state)
      S_IDLE: begin
        if (operand.valid) begin
          if (operand.value == '0) begin
            // zero has no factors: drop the request
            state_next = S_IDLE;
          end else if (operand.value == VALUE_BITS'(1)) begin
            out_factor_next = VALUE_BITS'(1);
            out_last_next   = 1'b1;
            state_next      = S_OUT;
          end else begin
            // start trials at divisor 2
            rem_next     = operand.value;
            d_next       = VALUE_BITS'(2);
            div_start    = 1'b1;
            div_dividend = operand.value;
            div_divisor  = VALUE_BITS'(2);
            state_next   = S_DIV;
          end
        end
      end

      S_DIV: begin
        if (div_stat.done) begin
          if (d > div_quot) begin
            // divisor squared beyond remainder: remainder is prime
            out_factor_next = rem;
            out_last_next   = 1'b1;
            state_next      = S_OUT;
          end else if (div_rem == '0) begin
            // divisor fits: emit it and divide it out
            rem_next        = div_quot;
            out_factor_next = d;
            out_last_next   = (div_quot == VALUE_BITS'(1));
            state_next      = S_OUT;
          end else begin
            // miss: advance the divisor and go again at once
            d_next      = d + VALUE_BITS'(1);
            div_start   = 1'b1;
            div_divisor = d + VALUE_BITS'(1);
          end
        end
      end

      S_OUT: begin
        if (result.ready) begin
          if (out_last) begin
            state_next = S_IDLE;
          end else begin
            // retry the same divisor on the reduced remainder
            div_start  = 1'b1;
            state_next = S_DIV;
          end
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // payload registers need no reset
  always_ff @(posedge clk) begin
    rem        <= rem_next;
    d          <= d_next;
    out_factor <= out_factor_next;
    out_last   <= out_last_next;
  end

  assign operand.ready = (state == S_IDLE);
  assign result.valid  = (state == S_OUT);
  assign result.factor = out_factor;
  assign result.last   = out_last;

endmodule

// ----- rtl/pf_checker.sv -----
// ----------------------------------------------------------------------------
// pf_checker: port-level checks for the prime factorizer
// Watches the operand and result channels over time; bound to the top level.
// ----------------------------------------------------------------------------
module pf_checker import pf_pkg::*; #(
  parameter int VALUE_BITS = VALUE_BITS_DEFAULT
) (
  input logic                  clk,
  input logic                  rst,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic [VALUE_BITS-1:0] in_value,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [VALUE_BITS-1:0] out_factor,
  input logic                  out_last
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_factor) && $stable(out_last))
    else $error("result dropped or changed while stalled");

  // one item at a time: no new request while a result is shown
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("operand ready while a result is pending");

  // a non-zero value keeps the block busy in the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (in_value != '0) |=> !in_ready)
    else $error("operand ready straight after a non-zero request");

  // value one gives the single factor one at once
  a_value_one: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (in_value == VALUE_BITS'(1))
      |=> out_valid && (out_factor == VALUE_BITS'(1)) && out_last)
    else $error("value one did not give the single factor one");

endmodule

bind prime_factorizer_top pf_checker #(
  .VALUE_BITS (VALUE_BITS)
) u_pf_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (operand.valid),
  .in_ready   (operand.ready),
  .in_value   (operand.value),
  .out_valid  (result.valid),
  .out_ready  (result.ready),
  .out_factor (result.factor),
  .out_last   (result.last)
);

// ----- tb/prime_factorizer_top_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// prime_factorizer_top_test: self-checking bench for the prime factorizer
// Offers corner and random values, predicts each factor by trial division in
// the bench and compares every result request against it. Runs with and
// without sender gaps and receiver stalls, plus one long result hold-off.
// ----------------------------------------------------------------------------
module prime_factorizer_top_test;
  import pf_pkg::*;

  localparam int VALUE_BITS = VALUE_BITS_DEFAULT;

  // Longest quiet stretch allowed: the widest prime (2^31 - 1) needs some
  // 46341 divider passes without a single request moving.
  localparam int unsigned QUIET_LIMIT     = 5_000_000;
  localparam int unsigned DRAIN_CYCLES    = 200;
  localparam int unsigned HOLD_OFF_CYCLES = 400;
  // Random values are kept to those needing at most this many divider passes
  localparam int unsigned TRIAL_BUDGET    = 600;
  localparam int unsigned NO_BUDGET       = 32'hFFFF_FFFF;
  localparam int unsigned RANDOM_PER_PHASE = 19;

  typedef bit [VALUE_BITS-1:0] value_t;

  typedef struct packed {
    value_t factor;
    bit     last;
  } factor_t;

  logic clk;
  logic rst;

  pf_value_if  #(.VALUE_BITS(VALUE_BITS)) operand ();
  pf_factor_if #(.VALUE_BITS(VALUE_BITS)) result ();

  prime_factorizer_top #(.VALUE_BITS(VALUE_BITS)) i_dut (
    .clk     (clk),
    .rst     (rst),
    .operand (operand.sink),
    .result  (result.source)
  );

  // Factors still owed by the block, oldest first
  factor_t pending_factors[$];

  int unsigned gap_pct;
  int unsigned stall_pct;
  bit          hold_request;
  int unsigned error_count;
  int unsigned values_accepted;
  int unsigned factors_checked;
  int unsigned quiet_cycles;

  // ---------------------------------------------------------------------------
  // Clock: 10 ns period
  // ---------------------------------------------------------------------------
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // ---------------------------------------------------------------------------
  // Trial-division predictor. Divide out each divisor that fits, step the
  // divisor on a miss, stop once divisor squared exceeds the remainder and
  // emit what is left. With record set the factors are queued as expected
  // results; the return value is the number of divider passes, used to keep
  // random values cheap. Stop early once the budget is exceeded.
  // ---------------------------------------------------------------------------
  function automatic int unsigned factorize(input value_t value, input bit record,
                                            input int unsigned budget);
    longint unsigned remainder;
    longint unsigned divisor;
    int unsigned     trials;
    factor_t         entry;
    remainder = value;
    divisor   = 2;
    trials    = 0;
    // Zero is outside the range: the block swallows it without a result
    if (remainder == 0) return 0;
    // One is its own single factor
    if (remainder == 1) begin
      if (record) begin
        entry.factor = value_t'(1);
        entry.last   = 1'b1;
        pending_factors.push_back(entry);
      end
      return 0;
    end
    while (divisor <= remainder / divisor && trials <= budget) begin
      trials++;
      if (remainder % divisor == 0) begin
        remainder = remainder / divisor;
        if (record) begin
          entry.factor = divisor[VALUE_BITS-1:0];
          entry.last   = (remainder == 1);
          pending_factors.push_back(entry);
        end
      end else begin
        divisor++;
      end
    end
    // Whatever is left above one is prime and closes the list
    if (remainder > 1 && record) begin
      entry.factor = remainder[VALUE_BITS-1:0];
      entry.last   = 1'b1;
      pending_factors.push_back(entry);
    end
    return trials;
  endfunction

  // ---------------------------------------------------------------------------
  // Random value of one of several shapes: full width, small, smooth products,
  // shifted small numbers (many factors of two, high bits set) and odd values
  // that are often prime. Drop any draw that would keep the divider busy for
  // too long.
  // ---------------------------------------------------------------------------
  function automatic value_t draw_value();
    value_t          candidate;
    longint unsigned product;
    int unsigned     shape;
    int unsigned     multiplier;
    shape = $urandom_range(99);
    for (int tries = 0; tries < 500; tries++) begin
      if (shape < 40) begin
        candidate = value_t'($urandom());
      end else if (shape < 65) begin
        candidate = value_t'($urandom_range(4095, 1));
      end else if (shape < 80) begin
        product = 1;
        repeat ($urandom_range(30, 1)) begin
          multiplier = $urandom_range(13, 2);
          if (product * multiplier < (64'd1 << VALUE_BITS)) product = product * multiplier;
        end
        candidate = value_t'(product);
      end else if (shape < 90) begin
        candidate = value_t'(longint'($urandom_range(255, 1)) << $urandom_range(30, 0));
      end else begin
        candidate = value_t'($urandom_range(262143, 1) | 1);
      end
      if (candidate != 0 && factorize(candidate, 1'b0, TRIAL_BUDGET) <= TRIAL_BUDGET)
        return candidate;
    end
    return value_t'($urandom_range(4095, 1));
  endfunction

  // ---------------------------------------------------------------------------
  // Offer one value and hold it until the block takes it. Valid stays high
  // between back-to-back values; drop it only for a random sender gap.
  // ---------------------------------------------------------------------------
  task automatic send_value(input value_t value);
    while ($urandom_range(99) < gap_pct) begin
      operand.valid <= 1'b0;
      @(posedge clk);
    end
    operand.valid <= 1'b1;
    operand.value <= value;
    @(posedge clk);
    while (!operand.ready) @(posedge clk);
  endtask

  // Drop valid and wait until every owed factor has come back, then let the
  // block settle in case the last value was one that yields nothing.
  task automatic wait_drained();
    operand.valid <= 1'b0;
    @(posedge clk);
    while (pending_factors.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Test: corner values, with no idling on either side
  // ---------------------------------------------------------------------------
  task automatic test_corner_values();
    value_t corners[$];
    gap_pct   = 0;
    stall_pct = 0;
    corners = '{
      value_t'(0),           // outside the range: no result at all
      value_t'(1),           // single factor one
      value_t'(2), value_t'(3), value_t'(4), value_t'(6), value_t'(12),
      value_t'(25), value_t'(49),           // divisor squared equals remainder
      value_t'(97),
      value_t'(720720),                     // many distinct small primes
      value_t'(1042441),                    // square of the prime 1021
      value_t'(1052651),                    // 1021 * 1031
      value_t'(1048573),                    // prime just below 2^20
      value_t'(1073741824),                 // 2^30: thirty factors, the most
      value_t'(1162261467),                 // 3^19
      value_t'(1431655765),                 // alternating bits, ones high
      value_t'(715827882),                  // alternating bits, ones low
      value_t'(2147483646),                 // largest even value
      value_t'(2147483647)                  // all ones, prime: the slowest item
    };
    foreach (corners[i]) send_value(corners[i]);
    wait_drained();
  endtask

  // ---------------------------------------------------------------------------
  // Test: random values under one sender-gap and receiver-stall profile
  // ---------------------------------------------------------------------------
  task automatic test_random_values(input int unsigned sender_gap, input int unsigned
                                    receiver_stall);
    gap_pct   = sender_gap;
    stall_pct = receiver_stall;
    repeat (RANDOM_PER_PHASE) send_value(draw_value());
    wait_drained();
  endtask

  // ---------------------------------------------------------------------------
  // Test: long result hold-off. The receiver holds ready low while the sender
  // keeps offering values, so the output register fills and the operand side
  // stalls until the hold is released.
  // ---------------------------------------------------------------------------
  task automatic test_result_hold_off();
    gap_pct      = 0;
    stall_pct    = 0;
    hold_request = 1'b1;
    send_value(value_t'(1073741824));
    send_value(value_t'(720720));
    send_value(value_t'(1162261467));
    send_value(draw_value());
    wait_drained();
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: random ready per cycle; on request hold ready low for a long
  // stretch, counted here, then release.
  // ---------------------------------------------------------------------------
  initial begin
    result.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        result.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_request = 1'b0;
      end
      result.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Checker: queue the predicted factors of each accepted value, compare each
  // accepted result with the oldest one owed.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    factor_t got;
    factor_t want;
    if (!rst) begin
      if (operand.valid && operand.ready) begin
        void'(factorize(operand.value, 1'b1, NO_BUDGET));
        values_accepted++;
      end
      if (result.valid && result.ready) begin
        got.factor = result.factor;
        got.last   = result.last;
        factors_checked++;
        if (pending_factors.size() == 0) begin
          $error("unexpected result: factor %0d, last %0b", got.factor, got.last);
          error_count++;
        end else begin
          want = pending_factors.pop_front();
          if (got.factor !== want.factor) begin
            $error("factor: expected %0d, got %0d", want.factor, got.factor);
            error_count++;
          end
          if (got.last !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, got.last);
            error_count++;
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: end the run if no request moves on either channel for too long
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst || (operand.valid && operand.ready) || (result.valid && result.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Timeout: no request moved for %0d cycles, %0d factors owed",
               quiet_cycles, pending_factors.size());
      $display("prime_factorizer_top test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    error_count     = 0;
    values_accepted = 0;
    factors_checked = 0;
    hold_request    = 1'b0;
    gap_pct         = 0;
    stall_pct       = 0;
    rst            <= 1'b1;
    operand.valid  <= 1'b0;
    operand.value  <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_corner_values();
    test_random_values(0, 0);
    test_random_values(55, 0);
    test_random_values(0, 55);
    test_random_values(38, 38);
    test_result_hold_off();

    if (pending_factors.size() != 0) begin
      $error("%0d expected factors never arrived", pending_factors.size());
      error_count++;
    end
    $display("Checked %0d factors from %0d values: corner values, random values",
             factors_checked, values_accepted);
    $display("under four idling profiles, and a long result hold-off.");
    if (error_count == 0) begin
      $display("prime_factorizer_top test passed");
    end else begin
      $display("prime_factorizer_top test failed");
    end
    $finish;
  end

endmodule
